FILE: rtl/dtf_pkg.sv
// dtf_pkg: shared types, constants and tables for the double to fixed decimal text block.
// No dependencies. Used by dtf_front, dtf_fifo, dtf_back and the top level.
`timescale 1ns / 1ps
package dtf_pkg;

  localparam int unsigned MaxPrecDefault = 18;
  localparam int unsigned PrecW          = 5;
  localparam int unsigned WholeW         = 31;
  localparam int unsigned MantW          = 53;
  localparam int unsigned ShW            = 11;
  localparam int unsigned PowW           = 60;
  localparam int unsigned FracW          = 61;
  localparam int unsigned NumPow         = 19;

  localparam logic [PrecW-1:0] PrecReset = 5'd6;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharNone  = 8'h00;

  // powers of ten, 10^0 .. 10^18
  localparam logic [PowW-1:0] Pow10 [NumPow] = '{
    60'd1,
    60'd10,
    60'd100,
    60'd1000,
    60'd10000,
    60'd100000,
    60'd1000000,
    60'd10000000,
    60'd100000000,
    60'd1000000000,
    60'd10000000000,
    60'd100000000000,
    60'd1000000000000,
    60'd10000000000000,
    60'd100000000000000,
    60'd1000000000000000,
    60'd10000000000000000,
    60'd100000000000000000,
    60'd1000000000000000000
  };

  // one classified word, front to back
  typedef struct packed {
    logic              neg;
    logic              err;
    logic [WholeW-1:0] whole;
    logic [MantW-1:0]  pm;    // fraction bits of the value, weight 2^-sh
    logic [ShW-1:0]    sh;
    logic [PrecW-1:0]  prec;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

FILE: rtl/dtf_front.sv
// dtf_front: precision register on the APB-style port and classification of each word.
// Depends on dtf_pkg.
`timescale 1ns / 1ps
module dtf_front import dtf_pkg::*; #(
  parameter int unsigned MaxPrec = MaxPrecDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic [63:0] value_bits_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  input  fifo_stat_t  stat_i,
  output logic        push_o,
  output item_t       item_o
);

  logic [PrecW-1:0] prec_q;
  logic [10:0]      expo;
  logic [MantW-1:0] mant;
  logic [ShW-1:0]   sh;
  logic             big;
  logic [MantW-1:0] whole_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prec_q <= PrecReset;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      prec_q <= pwdata[PrecW-1:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : {{(32-PrecW){1'b0}}, prec_q};

  always_comb begin
    expo       = value_bits_i[62:52];
    mant       = {expo != 11'd0, value_bits_i[51:0]};
    sh         = (expo == 11'd0) ? 11'd1074 : 11'd1075 - expo;
    big        = sh >= 11'd53;
    whole_full = mant >> sh[5:0];

    item_o.neg   = value_bits_i[63] && (value_bits_i[62:0] != 63'd0);
    item_o.err   = expo >= 11'd1054;  // NaN, infinity or magnitude of 2^31 and up
    item_o.whole = big ? '0 : whole_full[WholeW-1:0];
    item_o.pm    = big ? mant : (mant & ~({MantW{1'b1}} << sh[5:0]));
    item_o.sh    = sh;
    item_o.prec  = (prec_q > PrecW'(MaxPrec)) ? PrecW'(MaxPrec) : prec_q;
  end

  assign push_o = start && !stat_i.full;

endmodule

FILE: rtl/dtf_fifo.sv
// dtf_fifo: two-entry queue of classified words between front and back.
// Depends on dtf_pkg.
`timescale 1ns / 1ps
module dtf_fifo import dtf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  item_t      item_i,
  input  logic       pop_i,
  output item_t      item_o,
  output fifo_stat_t stat_o
);

  item_t      mem_q [2];
  logic       wr_q;
  logic       rd_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  assign item_o       = mem_q[rd_q];
  assign stat_o.full  = cnt_q == 2'd2;
  assign stat_o.empty = cnt_q == 2'd0;

endmodule

FILE: rtl/dtf_back.sv
// dtf_back: fraction scaling in double rounding, carry, then one character per cycle but for skipped zeros.
// Depends on dtf_pkg.
`timescale 1ns / 1ps
module dtf_back import dtf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  item_t      item_i,
  input  fifo_stat_t stat_i,
  output logic       pop_o,
  output logic       out_valid_o,
  output logic [7:0] out_char_o,
  output logic       last_char_o,
  output logic       range_error_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_NORM, S_RND1, S_SUM, S_RND2, S_CARRY,
    S_SIGN, S_WHOLE, S_DOT, S_FRAC, S_ERR
  } state_e;

  state_e             state_q;
  logic               neg_q;
  logic [PrecW-1:0]   prec_q;
  logic [ShW-1:0]     sh_q;
  logic [MantW-1:0]   pm_q;
  logic [PowW-1:0]    m_q;
  logic [31:0]        whole_q;
  logic [2:0]         cnt_q;
  logic [63:0]        pp_q;
  logic [1:0]         ppsh_q;
  logic [127:0]       x_q;
  logic [6:0]         lz_q;
  logic [2:0]         nstep_q;
  logic [MantW-1:0]   s_q;
  logic signed [12:0] q_q;
  logic [116:0]       t_q;
  logic               st_q;
  logic [FracW-1:0]   frac_q;
  logic [FracW-1:0]   rem_q;
  logic [4:0]         j_q;
  logic               started_q;
  logic               out_valid_q;
  logic [7:0]         out_char_q;
  logic               last_q;
  logic               err_q;

  // multiply
  logic [31:0]  a_sel, b_sel;
  logic [63:0]  pp_n;
  logic [127:0] acc_add;
  // normalize
  logic [6:0]   w;
  logic [127:0] hmask;
  logic         hz;
  // first rounding
  logic [53:0]        s54;
  logic signed [12:0] q_n;
  // alignment and +0.5
  logic signed [12:0] qa;
  logic [168:0]       wide;
  logic [116:0]       t_n;
  logic               tiny;
  // second rounding
  logic signed [12:0] qc, bp;
  logic [6:0]         r7;
  logic               up;
  logic [116:0]       kept, rounded;
  logic [FracW-1:0]   frac_n;
  // carry
  logic               ge_m;
  logic [31:0]        whole_n;
  // digit unit
  logic [63:0]        pw, rem64;
  logic [63:0]        mlt [10];
  logic [3:0]         dig;
  logic [63:0]        sub;

  always_comb begin
    a_sel   = cnt_q[0] ? {11'd0, pm_q[52:32]} : pm_q[31:0];
    b_sel   = cnt_q[1] ? {4'd0, m_q[59:32]} : m_q[31:0];
    pp_n    = a_sel * b_sel;
    acc_add = {64'd0, pp_q} << {ppsh_q, 5'd0};

    w     = 7'd64 >> nstep_q;
    hmask = ~({128{1'b1}} >> w);
    hz    = (x_q & hmask) == 128'd0;

    // round the exact product to 53 bits, nearest even
    s54 = {1'b0, x_q[127:75]}
        + {53'd0, x_q[74] && ((|x_q[73:0]) || x_q[75])};
    q_n = 13'sd127 - $signed({6'd0, lz_q}) - $signed({2'd0, sh_q})
        + $signed({12'd0, s54[53]});

    // fixed point with 56 fraction bits, lost bits kept as sticky
    tiny = q_q < -13'sd57;
    qa   = q_q + 13'sd57;
    wide = {116'd0, s_q} << qa[6:0];
    t_n  = {1'b0, wide[168:53]} + (117'd1 << 55);

    // round the sum to 53 bits, nearest even, then truncate
    qc      = (q_q < -13'sd1) ? -13'sd1 : q_q;
    bp      = qc + 13'sd57;
    r7      = qc[6:0] + 7'd4 + {6'd0, t_q[bp[6:0]]};
    up      = t_q[r7 - 7'd1]
            && ((|(t_q & ((117'd1 << (r7 - 7'd1)) - 117'd1))) || st_q || t_q[r7]);
    kept    = t_q & ~((117'd1 << r7) - 117'd1);
    rounded = kept + (up ? (117'd1 << r7) : 117'd0);
    frac_n  = rounded[116:56];

    ge_m    = frac_q >= {1'b0, m_q};
    whole_n = ge_m ? whole_q + 32'd1 : whole_q;

    pw     = {4'd0, Pow10[j_q]};
    rem64  = {3'd0, rem_q};
    mlt[0] = 64'd0;
    mlt[1] = pw;
    mlt[2] = pw << 1;
    mlt[3] = (pw << 1) + pw;
    mlt[4] = pw << 2;
    mlt[5] = (pw << 2) + pw;
    mlt[6] = (pw << 2) + (pw << 1);
    mlt[7] = (pw << 3) - pw;
    mlt[8] = pw << 3;
    mlt[9] = (pw << 3) + pw;
    dig    = 4'd0;
    for (int d = 1; d < 10; d++) begin
      dig = dig + {3'd0, rem64 >= mlt[d]};
    end
    sub = mlt[dig];
  end

  assign pop_o = (state_q == S_IDLE) && !stat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      neg_q       <= 1'b0;
      prec_q      <= '0;
      sh_q        <= '0;
      pm_q        <= '0;
      m_q         <= '0;
      whole_q     <= '0;
      cnt_q       <= '0;
      pp_q        <= '0;
      ppsh_q      <= '0;
      x_q         <= '0;
      lz_q        <= '0;
      nstep_q     <= '0;
      s_q         <= '0;
      q_q         <= '0;
      t_q         <= '0;
      st_q        <= 1'b0;
      frac_q      <= '0;
      rem_q       <= '0;
      j_q         <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      last_q      <= 1'b0;
      err_q       <= 1'b0;
    end else begin
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
      err_q       <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (!stat_i.empty) begin
            neg_q   <= item_i.neg;
            prec_q  <= item_i.prec;
            sh_q    <= item_i.sh;
            pm_q    <= item_i.pm;
            m_q     <= Pow10[item_i.prec];
            whole_q <= {1'b0, item_i.whole};
            x_q     <= '0;
            lz_q    <= '0;
            cnt_q   <= '0;
            state_q <= item_i.err ? S_ERR : S_MUL;
          end
        end
        S_MUL: begin
          // four 32x32 partial products, each accumulated the cycle after
          if (cnt_q != 3'd4) begin
            pp_q   <= pp_n;
            ppsh_q <= {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};
          end
          if (cnt_q != 3'd0) x_q <= x_q + acc_add;
          cnt_q   <= cnt_q + 3'd1;
          nstep_q <= '0;
          if (cnt_q == 3'd4) state_q <= S_NORM;
        end
        S_NORM: begin
          if (nstep_q == 3'd0 && x_q == 128'd0) begin
            frac_q  <= '0;
            state_q <= S_CARRY;
          end else begin
            if (hz) begin
              x_q  <= x_q << w;
              lz_q <= lz_q + w;
            end
            nstep_q <= nstep_q + 3'd1;
            if (nstep_q == 3'd6) state_q <= S_RND1;
          end
        end
        S_RND1: begin
          s_q     <= s54[53] ? s54[53:1] : s54[52:0];
          q_q     <= q_n;
          state_q <= S_SUM;
        end
        S_SUM: begin
          if (tiny) begin
            frac_q  <= '0;
            state_q <= S_CARRY;
          end else begin
            t_q     <= t_n;
            st_q    <= |wide[52:0];
            state_q <= S_RND2;
          end
        end
        S_RND2: begin
          frac_q  <= frac_n;
          state_q <= S_CARRY;
        end
        S_CARRY: begin
          if (ge_m) frac_q <= '0;
          rem_q     <= {29'd0, whole_n};
          j_q       <= 5'd9;
          started_q <= 1'b0;
          if (whole_n[31]) begin
            state_q <= S_ERR;
          end else begin
            state_q <= neg_q ? S_SIGN : S_WHOLE;
          end
        end
        S_SIGN: begin
          out_valid_q <= 1'b1;
          out_char_q  <= CharMinus;
          state_q     <= S_WHOLE;
        end
        S_WHOLE: begin
          // leading zeros are skipped without a strobe
          if (dig != 4'd0 || j_q == 5'd0 || started_q) begin
            out_valid_q <= 1'b1;
            out_char_q  <= CharZero + {4'd0, dig};
            started_q   <= 1'b1;
            rem_q       <= rem_q - sub[FracW-1:0];
          end
          if (j_q == 5'd0) begin
            state_q <= S_DOT;
          end else begin
            j_q <= j_q - 5'd1;
          end
        end
        S_DOT: begin
          out_valid_q <= 1'b1;
          out_char_q  <= CharDot;
          last_q      <= prec_q == '0;
          rem_q       <= frac_q;
          j_q         <= prec_q - 5'd1;
          state_q     <= (prec_q == '0) ? S_IDLE : S_FRAC;
        end
        S_FRAC: begin
          out_valid_q <= 1'b1;
          out_char_q  <= CharZero + {4'd0, dig};
          last_q      <= j_q == 5'd0;
          rem_q       <= rem_q - sub[FracW-1:0];
          j_q         <= j_q - 5'd1;
          if (j_q == 5'd0) state_q <= S_IDLE;
        end
        S_ERR: begin
          out_valid_q <= 1'b1;
          out_char_q  <= CharNone;
          last_q      <= 1'b1;
          err_q       <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_char_o    = out_char_q;
  assign last_char_o   = last_q;
  assign range_error_o = err_q;

endmodule

FILE: rtl/double_to_fixed_decimal_text.sv
// double_to_fixed_decimal_text: top level, front classifier, word queue and formatter back end.
// Depends on dtf_pkg, dtf_front, dtf_fifo, dtf_back.
//
//   channel  direction  handshake               payload
//   input    in         start / busy            value_bits_i
//   result   out        out_valid_o (strobe)    out_char_o, last_char_o, range_error_o
//   config   in/out     psel, penable, pready   paddr, pwdata, prdata (precision)
//
// A word passes through intake, multiply, normalize, then rounding and carry (a zero fraction
// skips normalize and rounding), then comes out one character per cycle, apart from leading
// zeros of the whole part, which are skipped with no character.
// An error caught at intake skips the conversion; a carry past 2147483647 ends in the error word
// after the conversion. The back end handles one word at a time; the two-entry queue
// lets start be taken while it works. busy is high when the queue is full.
// Reset clears the queue and the back end and sets precision to 6. Results cannot stall.
`timescale 1ns / 1ps
module double_to_fixed_decimal_text import dtf_pkg::*; #(
  parameter int unsigned MaxPrec = MaxPrecDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] value_bits_i,
  output logic        out_valid_o,
  output logic [7:0]  out_char_o,
  output logic        last_char_o,
  output logic        range_error_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  fifo_stat_t stat;
  logic       push;
  logic       pop;
  item_t      item_in;
  item_t      item_out;

  assign pready = 1'b1;
  assign busy   = stat.full;

  dtf_front #(.MaxPrec(MaxPrec)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .value_bits_i(value_bits_i),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .stat_i      (stat),
    .push_o      (push),
    .item_o      (item_in)
  );

  dtf_fifo u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .item_i(item_in),
    .pop_i (pop),
    .item_o(item_out),
    .stat_o(stat)
  );

  dtf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_out),
    .stat_i       (stat),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_char_o   (out_char_o),
    .last_char_o  (last_char_o),
    .range_error_o(range_error_o)
  );

  a_err_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && range_error_o |-> last_char_o && out_char_o == CharNone)
    else $error("error word not a single terminal result");

  a_err_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_char_o |-> !range_error_o)
    else $error("range error flagged inside text");

  a_prec_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready && !paddr[2]
      |=> paddr[2] || prdata[4:0] == $past(pwdata[4:0]))
    else $error("precision write lost");

endmodule

FILE: test/double_to_fixed_decimal_text_checker.sv
// double_to_fixed_decimal_text_checker: watches the input, config and result ports of the
// formatter, predicts each word's text and compares it character by character.
// Depends on the block's port list only; hands a failure count back to the tb top.
`timescale 1ns / 1ps
module double_to_fixed_decimal_text_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] value_bits_i,
  input  logic        out_valid_o,
  input  logic [7:0]  out_char_o,
  input  logic        last_char_o,
  input  logic        range_error_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);

  localparam logic [2:0] AddrPrecision = 3'd0;
  localparam int unsigned PrecLimit = 18;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       err;
  } text_char_t;

  text_char_t  text_q[$];
  logic [4:0]  precision;

  function automatic void push_char(logic [7:0] ch, logic last, logic err);
    text_char_t c;
    c.ch = ch;
    c.last = last;
    c.err = err;
    text_q.push_back(c);
  endfunction

  // expected text of one word, appended to text_q
  function automatic void format_value(logic [63:0] bits);
    real         v;
    real         mult;
    real         part;
    real         rnd;
    longint      whole;
    longint      frac;
    longint      lim;
    int unsigned p;
    int          nd;
    logic [7:0]  digs[12];
    logic [7:0]  fdig[PrecLimit];
    logic        neg;
    p = (precision > PrecLimit) ? PrecLimit : precision;
    if (bits[62:52] == 11'h7FF) begin
      push_char(8'h00, 1'b1, 1'b1);
      return;
    end
    v = $bitstoreal(bits);
    neg = v < 0.0;
    if (neg) v = -v;
    if (v >= 2147483648.0) begin
      push_char(8'h00, 1'b1, 1'b1);
      return;
    end
    mult = 1.0;
    for (int i = 0; i < p; i++) mult = mult * 10.0;
    whole = $rtoi(v);
    part = v - real'(whole);
    rnd = part * mult;
    rnd = rnd + 0.5;
    // truncate; longint cast rounds
    frac = longint'(rnd);
    if (real'(frac) > rnd) frac = frac - 1;
    lim = longint'(mult);
    if (frac >= lim) begin
      whole = whole + 1;
      frac = 0;
    end
    if (whole > 64'sd2147483647) begin
      push_char(8'h00, 1'b1, 1'b1);
      return;
    end
    if (neg) push_char("-", 1'b0, 1'b0);
    nd = 0;
    do begin
      digs[nd] = 8'h30 + 8'(whole % 10);
      whole = whole / 10;
      nd++;
    end while (whole > 0);
    while (nd > 0) begin
      nd--;
      push_char(digs[nd], 1'b0, 1'b0);
    end
    push_char(".", p == 0, 1'b0);
    for (int i = p; i > 0; i--) begin
      fdig[i-1] = 8'h30 + 8'(frac % 10);
      frac = frac / 10;
    end
    for (int i = 0; i < p; i++) push_char(fdig[i], i + 1 == p, 1'b0);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    text_char_t exp_c;
    if (!rst_ni) begin
      precision = 5'd6;
      text_q.delete();
      fail_count_o = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == AddrPrecision)
        precision = pwdata[4:0];
      if (start && !busy) format_value(value_bits_i);
      if (out_valid_o) begin
        if (text_q.size() == 0) begin
          $display("%0t: unexpected word char=%h last=%b err=%b", $time, out_char_o,
                   last_char_o, range_error_o);
          fail_count_o++;
        end else begin
          exp_c = text_q.pop_front();
          if (exp_c.ch !== out_char_o || exp_c.last !== last_char_o ||
              exp_c.err !== range_error_o) begin
            $display("%0t: mismatch expected char=%h last=%b err=%b, got char=%h last=%b err=%b",
                     $time, exp_c.ch, exp_c.last, exp_c.err, out_char_o, last_char_o,
                     range_error_o);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = text_q.size();
  end

endmodule

FILE: test/double_to_fixed_decimal_text_tb.sv
// double_to_fixed_decimal_text_tb: stimulus and verdict for the decimal text formatter.
// Depends on double_to_fixed_decimal_text and double_to_fixed_decimal_text_checker.
`timescale 1ns / 1ps
module double_to_fixed_decimal_text_tb;

  localparam logic [2:0] AddrPrecision = 3'd0;
  localparam int StallLimit = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] value_bits_i = '0;
  logic        out_valid_o;
  logic [7:0]  out_char_o;
  logic        last_char_o;
  logic        range_error_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          stall_cycles = 0;
  int          idle_pct = 12;

  double_to_fixed_decimal_text dut (.*);

  double_to_fixed_decimal_text_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .value_bits_i, .out_valid_o, .out_char_o,
    .last_char_o, .range_error_o, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: cycles with no word moved on any port
  always @(posedge clk_i) begin
    if ((start && !busy) || out_valid_o || (psel && penable)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_precision(logic [31:0] val);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = AddrPrecision;
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic send_word(logic [63:0] bits);
    if ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    start = 1'b1;
    value_bits_i = bits;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // drain: all text back, then slack for a word still in the back end
  task automatic drain();
    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand_value();
    real    v;
    longint m;
    case ($urandom_range(9))
      0, 1: rand_value = {$urandom, $urandom};
      2: begin
        case ($urandom_range(5))
          0: rand_value = 64'h7FF0_0000_0000_0000;
          1: rand_value = 64'hFFF8_0000_0000_0001;
          2: rand_value = {1'($urandom_range(1)), 63'h0};
          3: rand_value = {1'($urandom_range(1)), 11'h000, 20'h0, $urandom};
          4: rand_value = {1'($urandom_range(1)),
                           63'(63'h41DF_FFFF_FFC0_0000 + 63'($urandom_range(0, 63)))};
          default: rand_value = {1'($urandom_range(1)), 11'h7FF, 20'h0, $urandom};
        endcase
      end
      default: begin
        // ordinary decimal values, some with 0.5 added
        m = {$urandom_range(0, 65535), $urandom};
        v = real'(m);
        repeat ($urandom_range(0, 14)) v = v / 10.0;
        if ($urandom_range(3) == 0) v = v + 0.5;
        if ($urandom_range(1)) v = -v;
        rand_value = $realtobits(v);
      end
    endcase
  endfunction

  logic [63:0] directed[$] = '{
    64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h3FF8_0000_0000_0000,
    64'hBFF8_0000_0000_0000, 64'h3FEF_FFFF_FFFF_FFFF, 64'hBE7A_D7F2_9ABC_AF48,
    64'h41DF_FFFF_FFE6_6666, 64'h41DF_FFFF_FFC0_0000, 64'h41E0_0000_0000_0000,
    64'hC1E0_0000_0000_0000, 64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
    64'h7FF8_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
    64'h000F_FFFF_FFFF_FFFF, 64'h7FEF_FFFF_FFFF_FFFF, 64'h3FB9_9999_9999_999A,
    64'h4059_0000_0000_0000, 64'h3FE0_0000_0000_0000, 64'h4024_0000_0000_0000,
    64'h3EB0_C6F7_A0B5_ED8D
  };

  initial begin
    logic [31:0] settings[6];
    settings = '{32'd0, 32'd18, 32'd31, 32'd1, 32'd0, 32'd12};
    settings[4] = $urandom_range(0, 31);
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    idle_pct = 12;
    foreach (directed[i]) send_word(directed[i]);
    drain();
    write_precision(32'd0);
    foreach (directed[i]) send_word(directed[i]);
    drain();
    write_precision(32'd18);
    foreach (directed[i]) send_word(directed[i]);
    for (int seg = 0; seg < 6; seg++) begin
      drain();
      write_precision(settings[seg]);
      idle_pct = (seg < 2) ? 12 : (seg < 4) ? 70 : 0;
      repeat (19) send_word(rand_value());
    end
    drain();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/dtf_pkg.sv
rtl/dtf_front.sv
rtl/dtf_fifo.sv
rtl/dtf_back.sv
rtl/double_to_fixed_decimal_text.sv
test/double_to_fixed_decimal_text_checker.sv
test/double_to_fixed_decimal_text_tb.sv
